[hw/rtl/ultrasonic_echo_ranging_core_assert.svh]
// assertion macros for the rtl, included by uer_front
`ifndef ULTRASONIC_ECHO_RANGING_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGING_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define UER_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uer assertion failed");

// next-cycle implication
`define UER_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uer assertion failed");

`endif

[hw/rtl/uer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	localparam int UER_COUNT_WIDTH = 32;
	localparam int UER_FIFO_DEPTH  = 4;
	localparam int UER_IDX_W       = 2;
	localparam int UER_DATA_W      = 32;
	localparam int UER_RAW_W       = 32;
	localparam int UER_DIST_W      = 36;
	localparam int UER_TRIG_W      = 16;
	localparam int UER_SCALE_W     = 20;
	localparam int UER_FRAC_BITS   = 16;

	localparam logic [UER_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
	localparam logic [UER_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [UER_IDX_W-1:0] REG_SCALE_Q16     = 2'd2;

	localparam logic [UER_TRIG_W-1:0]  UER_TRIGGER_RST = 16'd240;
	localparam logic [UER_DATA_W-1:0]  UER_TIMEOUT_RST = 32'd12000000;
	localparam logic [UER_SCALE_W-1:0] UER_SCALE_RST   = 20'd472405;

	typedef struct packed {
		logic                  en;
		logic [UER_IDX_W-1:0]  index;
		logic [UER_DATA_W-1:0] data;
	} uer_cfg_wr_t;

	typedef struct packed {
		logic                 trig;
		logic                 busy;
		logic                 done;
		logic                 timed_out;
		logic [UER_RAW_W-1:0] raw;
	} uer_item_t;

	typedef struct packed {
		logic                  trig;
		logic                  busy;
		logic                  done;
		logic                  timed_out;
		logic [UER_RAW_W-1:0]  raw;
		logic [UER_DIST_W-1:0] distance;
	} uer_res_t;

	// count limit: timeout clamped to the counter range, zero acts as one
	function automatic logic [UER_DATA_W-1:0] clamp_limit(input logic [UER_DATA_W-1:0] v,
		input int cw);
		logic [UER_DATA_W-1:0] cmax;
		logic [UER_DATA_W-1:0] lim;
		cmax = UER_DATA_W'((64'd1 << cw) - 64'd1);
		lim  = (v > cmax) ? cmax : v;
		if (lim == '0) begin
			lim = UER_DATA_W'(1);
		end
		return lim;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ultrasonic_echo_ranging_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic echo ranging core. Each pushed word is one timer tick (start
// request and sampled echo level) and yields exactly one result word: trigger
// pin level, busy, done, and the timed_out flag, raw tick count and distance
// in micrometres of the last finished measurement. One tick is taken every
// clock cycle while the middle queue is not full; a result passes the middle
// queue, the registered raw-times-scale multiply in the back end and the output
// queue before it appears. Small queues between the tick sequencer and the
// multiply stage and at the output let either side stall without losing words.
// Configuration writes (trigger length, timeout, Q16 scale) take effect at
// once and belong in periods with no ticks in flight.
module ultrasonic_echo_ranging_core #(
	parameter int COUNT_WIDTH = uer_pkg::UER_COUNT_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic                            start_req,
	input  wire logic                            echo_level,
	input  wire logic                            wr_en,
	input  wire logic [uer_pkg::UER_IDX_W-1:0]   wr_index,
	input  wire logic [uer_pkg::UER_DATA_W-1:0]  wr_data,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic                                 trig_level,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic                                 timed_out,
	output logic [uer_pkg::UER_RAW_W-1:0]        raw_ticks,
	output logic [uer_pkg::UER_DIST_W-1:0]       distance_um
);

	import uer_pkg::*;

	uer_cfg_wr_t cfg_wr;
	uer_item_t   f_item;
	logic        f_push;
	logic        mid_full;
	uer_item_t   mid_item;
	logic        mid_empty;
	logic        mid_pop;
	uer_res_t    res;

	assign cfg_wr.en    = wr_en;
	assign cfg_wr.index = wr_index;
	assign cfg_wr.data  = wr_data;

	uer_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.start_req (start_req),
		.echo_level(echo_level),
		.cfg_wr    (cfg_wr),
		.item      (f_item),
		.item_push (f_push),
		.item_full (mid_full)
	);

	uer_fifo #(
		.WIDTH($bits(uer_item_t)),
		.DEPTH(UER_FIFO_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (f_item),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_item),
		.empty (mid_empty)
	);

	uer_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.item      (mid_item),
		.item_empty(mid_empty),
		.item_pop  (mid_pop),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

	assign trig_level  = res.trig;
	assign busy_res    = res.busy;
	assign done_res    = res.done;
	assign timed_out   = res.timed_out;
	assign raw_ticks   = res.raw;
	assign distance_um = res.distance;

endmodule

`default_nettype wire

[hw/rtl/uer_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module uer_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/uer_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module uer_front #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 start_req,
	input  wire logic                 echo_level,
	input  wire uer_pkg::uer_cfg_wr_t cfg_wr,
	output uer_pkg::uer_item_t        item,
	output logic                      item_push,
	input  wire logic                 item_full
);

	import uer_pkg::*;

	`include "ultrasonic_echo_ranging_core_assert.svh"

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	phase_t                  phase_q;
	phase_t                  phase_d;
	logic [COUNT_WIDTH-1:0]  cnt_q;
	logic [COUNT_WIDTH-1:0]  cnt_d;
	logic [COUNT_WIDTH-1:0]  cnt_inc;
	logic [UER_RAW_W-1:0]    cnt_inc_ext;
	logic [UER_RAW_W-1:0]    last_raw_q;
	logic [UER_RAW_W-1:0]    raw_d;
	logic                    last_to_q;
	logic                    to_d;
	logic [UER_TRIG_W-1:0]   tlen_q;
	logic [UER_DATA_W-1:0]   lim_q;
	logic                    trig;
	logic                    done;
	logic                    acc;

	assign full        = item_full;
	assign acc         = push && !item_full;
	assign cnt_inc     = cnt_q + COUNT_WIDTH'(1);
	assign cnt_inc_ext = UER_RAW_W'(cnt_inc);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		raw_d   = last_raw_q;
		to_d    = last_to_q;
		trig    = 1'b0;
		done    = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					trig = 1'b1;
					if (tlen_q == UER_TRIG_W'(1)) begin
						phase_d = PH_WAIT;
						cnt_d   = '0;
					end else begin
						phase_d = PH_TRIG;
						cnt_d   = COUNT_WIDTH'(1);
					end
				end
			end
			PH_TRIG: begin
				trig = 1'b1;
				if (cnt_inc_ext >= UER_RAW_W'(tlen_q)) begin
					phase_d = PH_WAIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					if (lim_q == UER_DATA_W'(1)) begin
						phase_d = PH_IDLE;
						cnt_d   = '0;
						raw_d   = lim_q;
						to_d    = 1'b1;
						done    = 1'b1;
					end else begin
						phase_d = PH_MEAS;
						cnt_d   = COUNT_WIDTH'(1);
					end
				end
			end
			PH_MEAS: begin
				if (!echo_level) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
					raw_d   = UER_RAW_W'(cnt_q);
					to_d    = 1'b0;
					done    = 1'b1;
				end else if (cnt_inc_ext >= lim_q) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
					raw_d   = lim_q;
					to_d    = 1'b1;
					done    = 1'b1;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	assign item_push      = acc;
	assign item.trig      = trig;
	assign item.busy      = (phase_d != PH_IDLE);
	assign item.done      = done;
	assign item.timed_out = to_d;
	assign item.raw       = raw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			last_raw_q <= '0;
			last_to_q  <= 1'b0;
			tlen_q     <= UER_TRIGGER_RST;
			lim_q      <= clamp_limit(UER_TIMEOUT_RST, COUNT_WIDTH);
		end else begin
			if (acc) begin
				phase_q    <= phase_d;
				cnt_q      <= cnt_d;
				last_raw_q <= raw_d;
				last_to_q  <= to_d;
			end
			if (cfg_wr.en) begin
				case (cfg_wr.index)
					REG_TRIGGER_TICKS: begin
						tlen_q <= (cfg_wr.data[UER_TRIG_W-1:0] == '0) ?
							UER_TRIG_W'(1) : cfg_wr.data[UER_TRIG_W-1:0];
					end
					REG_TIMEOUT_TICKS: begin
						lim_q <= clamp_limit(cfg_wr.data, COUNT_WIDTH);
					end
					default: begin
					end
				endcase
			end
		end
	end

	`UER_ASSERT_NOW(a_meas_count_nonzero, phase_q == PH_MEAS, cnt_q != '0)
	`UER_ASSERT_NOW(a_idle_count_clear, phase_q == PH_IDLE, cnt_q == '0)
	`UER_ASSERT_NEXT(a_done_returns_idle, acc && done, phase_q == PH_IDLE)

endmodule

`default_nettype wire

[hw/rtl/uer_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module uer_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire uer_pkg::uer_cfg_wr_t cfg_wr,
	input  wire uer_pkg::uer_item_t   item,
	input  wire logic                 item_empty,
	output logic                      item_pop,
	output uer_pkg::uer_res_t         res,
	output logic                      empty,
	input  wire logic                 pop
);

	import uer_pkg::*;

	localparam int PROD_W = UER_RAW_W + UER_SCALE_W;

	logic [UER_SCALE_W-1:0] scale_q;
	logic [PROD_W-1:0]      prod;
	logic [UER_DIST_W-1:0]  dist_val;
	logic [UER_DIST_W-1:0]  last_dist_q;
	uer_res_t               res_s1;
	logic                   res_vld_s1;
	logic                   ofifo_full;
	logic                   ofifo_push;
	logic                   adv;

	assign prod       = PROD_W'(item.raw) * PROD_W'(scale_q);
	assign dist_val   = prod[UER_FRAC_BITS +: UER_DIST_W];
	assign ofifo_push = res_vld_s1 && !ofifo_full;
	assign adv        = !res_vld_s1 || !ofifo_full;
	assign item_pop   = !item_empty && adv;

	always_ff @(posedge clk) begin
		if (item_pop) begin
			res_s1.trig      <= item.trig;
			res_s1.busy      <= item.busy;
			res_s1.done      <= item.done;
			res_s1.timed_out <= item.timed_out;
			res_s1.raw       <= item.raw;
			res_s1.distance  <= item.done ? dist_val : last_dist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s1  <= 1'b0;
			last_dist_q <= '0;
			scale_q     <= UER_SCALE_RST;
		end else begin
			if (item_pop) begin
				res_vld_s1 <= 1'b1;
			end else if (ofifo_push) begin
				res_vld_s1 <= 1'b0;
			end
			if (item_pop && item.done) begin
				last_dist_q <= dist_val;
			end
			if (cfg_wr.en && (cfg_wr.index == REG_SCALE_Q16)) begin
				scale_q <= cfg_wr.data[UER_SCALE_W-1:0];
			end
		end
	end

	uer_fifo #(
		.WIDTH($bits(uer_res_t)),
		.DEPTH(UER_FIFO_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (ofifo_push),
		.wdata (res_s1),
		.full  (ofifo_full),
		.pop   (pop),
		.rdata (res),
		.empty (empty)
	);

endmodule

`default_nettype wire

[test/ultrasonic_echo_ranging_core_tb.sv]
`timescale 1ns / 1ps

module ultrasonic_echo_ranging_core_tb;
	import uer_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int COUNT_W        = UER_COUNT_WIDTH;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int DRAIN_SLACK    = 4;
	localparam int END_SLACK      = 10;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [UER_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} ranging_phase_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  push       = 1'b0;
	logic                  start_req  = 1'b0;
	logic                  echo_level = 1'b0;
	logic                  wr_en      = 1'b0;
	logic [UER_IDX_W-1:0]  wr_index   = '0;
	logic [UER_DATA_W-1:0] wr_data    = '0;
	logic                  pop        = 1'b0;
	logic                  full;
	logic                  empty;
	logic                  trig_level;
	logic                  busy_res;
	logic                  done_res;
	logic                  timed_out;
	logic [UER_RAW_W-1:0]  raw_ticks;
	logic [UER_DIST_W-1:0] distance_um;

	// shadow of the configuration registers
	logic [UER_TRIG_W-1:0]  trig_len_cfg = UER_TRIGGER_RST;
	logic [UER_DATA_W-1:0]  timeout_cfg  = UER_TIMEOUT_RST;
	logic [UER_SCALE_W-1:0] scale_cfg    = UER_SCALE_RST;

	// predicted sequencer state
	ranging_phase_t        ph_state     = PH_IDLE;
	logic [31:0]           tick_cnt     = '0;
	logic [UER_RAW_W-1:0]  meas_raw     = '0;
	logic [UER_DIST_W-1:0] meas_dist    = '0;
	logic                  meas_timeout = 1'b0;

	uer_res_t pending_readings[$];
	int       mismatches = 0;
	int       items_sent = 0;
	bit       tx_no_gaps = 1'b0;
	bit       tx_calm    = 1'b0;
	bit       rx_calm    = 1'b0;
	bit       hold_req   = 1'b0;

	ultrasonic_echo_ranging_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start_req  (start_req),
		.echo_level (echo_level),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.empty      (empty),
		.pop        (pop),
		.trig_level (trig_level),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.timed_out  (timed_out),
		.raw_ticks  (raw_ticks),
		.distance_um(distance_um)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] count_limit();
		logic [63:0] cmax;
		logic [63:0] lim;
		cmax = (64'd1 << COUNT_W) - 64'd1;
		lim  = {32'd0, timeout_cfg};
		if (lim > cmax) begin
			lim = cmax;
		end
		if (lim == 64'd0) begin
			lim = 64'd1;
		end
		return lim[31:0];
	endfunction

	function automatic void close_measurement(input logic [31:0] raw, input logic to);
		logic [63:0] prod;
		prod         = {32'd0, raw} * {44'd0, scale_cfg};
		meas_raw     = raw;
		meas_timeout = to;
		meas_dist    = prod[UER_FRAC_BITS +: UER_DIST_W];
		ph_state     = PH_IDLE;
		tick_cnt     = '0;
	endfunction

	function automatic uer_res_t range_step(input logic start, input logic echo);
		uer_res_t    r;
		logic [31:0] tlen;
		logic [31:0] lim;
		logic        trig;
		logic        done;
		trig = 1'b0;
		done = 1'b0;
		tlen = (trig_len_cfg == '0) ? 32'd1 : {16'd0, trig_len_cfg};
		lim  = count_limit();
		case (ph_state)
			PH_IDLE: begin
				if (start) begin
					trig     = 1'b1;
					tick_cnt = 32'd1;
					if (tick_cnt >= tlen) begin
						ph_state = PH_WAIT;
						tick_cnt = '0;
					end else begin
						ph_state = PH_TRIG;
					end
				end
			end
			PH_TRIG: begin
				trig     = 1'b1;
				tick_cnt = tick_cnt + 32'd1;
				if (tick_cnt >= tlen) begin
					ph_state = PH_WAIT;
					tick_cnt = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					tick_cnt = 32'd1;
					ph_state = PH_MEAS;
					if (tick_cnt >= lim) begin
						close_measurement(lim, 1'b1);
						done = 1'b1;
					end
				end
			end
			default: begin
				if (!echo) begin
					close_measurement(tick_cnt, 1'b0);
					done = 1'b1;
				end else begin
					tick_cnt = tick_cnt + 32'd1;
					if (tick_cnt >= lim) begin
						close_measurement(lim, 1'b1);
						done = 1'b1;
					end
				end
			end
		endcase
		r.trig      = trig;
		r.busy      = (ph_state != PH_IDLE);
		r.done      = done;
		r.timed_out = meas_timeout;
		r.raw       = meas_raw;
		r.distance  = meas_dist;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		if (tx_no_gaps) begin
			return 0;
		end
		if ($urandom_range(0, 199) == 0) begin
			tx_calm = !tx_calm;
		end
		if (tx_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic int pick_stall();
		int r;
		if ($urandom_range(0, 299) == 0) begin
			rx_calm = !rx_calm;
		end
		if (rx_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(15, 40);
	endfunction

	task automatic send_tick(input logic start, input logic echo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push       <= 1'b0;
			start_req  <= 1'($urandom_range(0, 1));
			echo_level <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		start_req  <= start;
		echo_level <= echo;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_readings.push_back(range_step(start, echo));
		items_sent++;
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [UER_IDX_W-1:0] idx, input logic [UER_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_TRIGGER_TICKS: trig_len_cfg = data[UER_TRIG_W-1:0];
			REG_TIMEOUT_TICKS: timeout_cfg = data;
			REG_SCALE_Q16:     scale_cfg = data[UER_SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] trig_w, input logic [31:0] tmo_w,
		input logic [31:0] scl_w);
		write_reg(REG_TRIGGER_TICKS, trig_w);
		write_reg(REG_TIMEOUT_TICKS, tmo_w);
		write_reg(REG_SCALE_Q16, scl_w);
		end_writes();
	endtask

	task automatic random_config();
		int          r;
		logic [31:0] trig_w;
		logic [31:0] tmo_w;
		logic [31:0] scl_w;
		r = $urandom_range(0, 99);
		trig_w = (r < 70) ? $urandom_range(0, 6) : $urandom_range(7, 40);
		if ($urandom_range(0, 1)) begin
			trig_w[31:16] = 16'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 40) begin
			tmo_w = $urandom_range(0, 8);
		end else if (r < 70) begin
			tmo_w = $urandom_range(9, 60);
		end else begin
			tmo_w = $urandom;
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			scl_w = 32'd0;
		end else if (r < 30) begin
			scl_w = 32'h000F_FFFF;
		end else if (r < 45) begin
			scl_w = {12'd0, UER_SCALE_RST};
		end else begin
			scl_w = $urandom;
		end
		set_config(trig_w, tmo_w, scl_w);
	endtask

	// start, trigger, echo wait, echo high for a while, echo falls
	task automatic run_measurement();
		int          wait_len;
		int          high_len;
		int          n;
		logic [31:0] lim;
		lim = count_limit();
		wait_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 20);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: high_len = $urandom_range(1, 8);
			5, 6, 7: begin
				if (lim <= 32'd60) begin
					high_len = int'(lim) - 1 + int'($urandom_range(0, 2));
				end else begin
					high_len = $urandom_range(1, 30);
				end
			end
			default: high_len = $urandom_range(9, 30);
		endcase
		if (high_len < 1) begin
			high_len = 1;
		end
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (ph_state == PH_TRIG) begin
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		n = 0;
		while (ph_state == PH_WAIT && n < wait_len) begin
			send_tick(1'($urandom_range(0, 1)), 1'b0);
			n++;
		end
		n = 0;
		while (ph_state != PH_IDLE && n < high_len) begin
			send_tick(1'($urandom_range(0, 1)), 1'b1);
			n++;
		end
		if (ph_state != PH_IDLE) begin
			send_tick(1'($urandom_range(0, 1)), 1'b0);
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) begin
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_reset_values();
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	task automatic test_config_extremes();
		// zero trigger length, short timeout, full scale
		drain_results();
		set_config(32'd0, 32'd3, 32'h000F_FFFF);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		// zero timeout acts as one, zero scale
		drain_results();
		set_config(32'd1, 32'd0, 32'd0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		// longest trigger and timeout, cut short by a later write
		drain_results();
		set_config(32'h0000_FFFF, 32'hFFFF_FFFF, {12'd0, UER_SCALE_RST});
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		drain_results();
		write_reg(REG_TRIGGER_TICKS, 32'hABCD_0002);
		write_reg(REG_UNUSED, $urandom);
		end_writes();
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_results();
		write_reg(REG_SCALE_Q16, 32'hFFF1_2345);
		end_writes();
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic test_backpressure();
		drain_results();
		set_config(32'd2, 32'd10, $urandom);
		tx_no_gaps = 1'b1;
		hold_req   = 1'b1;
		repeat (30) begin
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		tx_no_gaps = 1'b0;
		drain_results();
	endtask

	task automatic test_random_ranging();
		int first;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			drain_results();
			random_config();
			repeat ($urandom_range(3, 10)) begin
				if ($urandom_range(0, 9) < 7) begin
					run_measurement();
				end else begin
					noise_burst();
				end
			end
		end
	endtask

	task automatic check_result();
		uer_res_t want;
		if (pending_readings.size() == 0) begin
			flag_mismatch("unexpected word", {28'd0, distance_um}, 64'd0);
			return;
		end
		want = pending_readings.pop_front();
		if (trig_level !== want.trig) begin
			flag_mismatch("trig_level", 64'(trig_level), 64'(want.trig));
		end
		if (busy_res !== want.busy) begin
			flag_mismatch("busy_res", 64'(busy_res), 64'(want.busy));
		end
		if (done_res !== want.done) begin
			flag_mismatch("done_res", 64'(done_res), 64'(want.done));
		end
		if (timed_out !== want.timed_out) begin
			flag_mismatch("timed_out", 64'(timed_out), 64'(want.timed_out));
		end
		if (raw_ticks !== want.raw) begin
			flag_mismatch("raw_ticks", 64'(raw_ticks), 64'(want.raw));
		end
		if (distance_um !== want.distance) begin
			flag_mismatch("distance_um", 64'(distance_um), 64'(want.distance));
		end
	endtask

	initial begin : result_checker
		int stall;
		int hold;
		stall = 0;
		hold  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_result();
			end
			if (hold_req) begin
				hold     = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				stall = pick_stall();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || wr_en || !arst_n) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_config_extremes();
		test_backpressure();
		test_random_ranging();
		test_backpressure();
		drain_results();
		repeat (END_SLACK) @(posedge clk);
		if (pending_readings.size() != 0) begin
			flag_mismatch("missing words", 64'(pending_readings.size()), 64'd0);
		end
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
